// ===== hdl/r2h_pkg.sv =====
`default_nettype none

package r2h_pkg;

   // Number of restoring steps in each divider, one quotient bit per step.
   localparam int DIV_STEPS = 16;

   // Hue in 1/64 degree units: sixty degrees and the full circle.
   localparam logic [14:0] HUE_SIXTY = 15'd3840;
   localparam logic [14:0] HUE_FULL  = 15'd23040;

   // Channel that holds the maximum, tested red first, then green.
   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   // First front-end stage: extremes, sector and the signed channel difference.
   typedef struct packed {
      logic [7:0]       hi;
      logic [7:0]       lo;
      sector_type       sector;
      logic signed [8:0] diff;
   } front_type;

   // Payload carried through the divider steps.
   // Each divider keeps a partial remainder and a register that shifts
   // dividend bits out at the top and quotient bits in at the bottom.
   typedef struct packed {
      logic [7:0]  hi;
      logic [7:0]  delta;
      logic        gray;
      sector_type  sector;
      logic        neg;
      logic [7:0]  sat_rem;
      logic [15:0] sat_dq;
      logic [7:0]  hue_rem;
      logic [15:0] hue_dq;
   } div_type;

endpackage

`default_nettype wire

// ===== hdl/r2h_front.sv =====
`default_nettype none

module r2h_front
   import r2h_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire logic [7:0] red,
   input  wire logic [7:0] green,
   input  wire logic [7:0] blue,
   output logic            out_valid,
   input  wire logic       out_ready,
   output div_type         out_data
);

   logic      a_valid_ff;
   front_type a_data_ff;
   front_type a_data_in;
   logic      a_ready;
   logic      b_valid_ff;
   div_type   b_data_ff;
   div_type   b_data_in;
   logic      b_ready;

   logic        r_ge_g;
   logic        r_ge_b;
   logic        g_ge_b;
   logic [7:0]  delta;
   logic [7:0]  mag;
   logic [19:0] hue_num;
   logic [23:0] sat_num;

   // Stage A: largest and smallest channel, sector and signed difference.
   always_comb begin
      r_ge_g = red >= green;
      r_ge_b = red >= blue;
      g_ge_b = green >= blue;
      a_data_in.hi = r_ge_g ? (r_ge_b ? red : blue) : (g_ge_b ? green : blue);
      a_data_in.lo = r_ge_g ? (g_ge_b ? blue : green) : (r_ge_b ? blue : red);
      if (r_ge_g && r_ge_b) begin
         a_data_in.sector = SECTOR_RED;
         a_data_in.diff   = $signed({1'b0, green}) - $signed({1'b0, blue});
      end else if (g_ge_b) begin
         a_data_in.sector = SECTOR_GREEN;
         a_data_in.diff   = $signed({1'b0, blue}) - $signed({1'b0, red});
      end else begin
         a_data_in.sector = SECTOR_BLUE;
         a_data_in.diff   = $signed({1'b0, red}) - $signed({1'b0, green});
      end
   end

   // Stage B: spread, magnitude of the difference and both dividends.
   always_comb begin
      delta   = a_data_ff.hi - a_data_ff.lo;
      mag     = a_data_ff.diff[8] ? 8'(-a_data_ff.diff) : a_data_ff.diff[7:0];
      // 3840 * mag as (mag << 12) - (mag << 8).
      hue_num = {mag, 12'd0} - {4'd0, mag, 8'd0};
      // 65535 * delta as (delta << 16) - delta.
      sat_num = {delta, 16'd0} - {16'd0, delta};
      b_data_in.hi      = a_data_ff.hi;
      b_data_in.delta   = delta;
      b_data_in.gray    = delta == 8'd0;
      b_data_in.sector  = a_data_ff.sector;
      b_data_in.neg     = a_data_ff.diff[8];
      b_data_in.sat_rem = sat_num[23:16];
      b_data_in.sat_dq  = sat_num[15:0];
      b_data_in.hue_rem = {4'd0, hue_num[19:16]};
      b_data_in.hue_dq  = hue_num[15:0];
   end

   assign a_ready  = !a_valid_ff || b_ready;
   assign b_ready  = !b_valid_ff || out_ready;
   assign in_ready = a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= in_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_data_ff <= a_data_in;
      end
      if (b_ready && a_valid_ff) begin
         b_data_ff <= b_data_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

endmodule

`default_nettype wire

// ===== hdl/r2h_div_step.sv =====
`default_nettype none

module r2h_div_step
   import r2h_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire div_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output div_type      out_data
);

   logic    valid_ff;
   div_type data_ff;
   div_type data_in;
   logic [8:0] sat_part;
   logic [8:0] hue_part;
   logic       sat_ge;
   logic       hue_ge;

   // One restoring step for each divider: shift in the next dividend bit,
   // subtract the divisor where it fits and record the quotient bit.
   always_comb begin
      data_in  = in_data;
      sat_part = {in_data.sat_rem, in_data.sat_dq[15]};
      hue_part = {in_data.hue_rem, in_data.hue_dq[15]};
      sat_ge   = sat_part >= {1'b0, in_data.hi};
      hue_ge   = hue_part >= {1'b0, in_data.delta};
      data_in.sat_rem = sat_ge ? 8'(sat_part - {1'b0, in_data.hi}) : sat_part[7:0];
      data_in.hue_rem = hue_ge ? 8'(hue_part - {1'b0, in_data.delta}) : hue_part[7:0];
      data_in.sat_dq  = {in_data.sat_dq[14:0], sat_ge};
      data_in.hue_dq  = {in_data.hue_dq[14:0], hue_ge};
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== hdl/r2h_finish.sv =====
`default_nettype none

module r2h_finish
   import r2h_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire div_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output logic [14:0]  hue,
   output logic [15:0]  saturation,
   output logic [7:0]   brightness,
   output logic         gray
);

   logic        valid_ff;
   logic [14:0] hue_ff;
   logic [14:0] hue_in;
   logic [15:0] sat_ff;
   logic [15:0] sat_in;
   logic [7:0]  bright_ff;
   logic        gray_ff;
   logic [14:0] base;
   logic [14:0] offset;
   logic [11:0] quot;
   logic        round_up;
   logic [15:0] hue_wide;

   // The hue quotient is below 4096, so only its low twelve bits matter.
   // A negative difference rounds toward minus infinity, hence the extra one
   // when the division left a remainder; the red sector then wraps by a
   // full circle.
   always_comb begin
      quot     = in_data.hue_dq[11:0];
      round_up = in_data.hue_rem != 8'd0;
      case (in_data.sector)
         SECTOR_RED:   base = 15'd0;
         SECTOR_GREEN: base = 15'(HUE_SIXTY * 2);
         SECTOR_BLUE:  base = 15'(HUE_SIXTY * 4);
         default:      base = 15'd0;
      endcase
      offset = (in_data.neg && in_data.sector == SECTOR_RED) ? HUE_FULL : base;
      if (in_data.neg) begin
         hue_wide = {1'b0, offset} - {4'd0, quot} - {15'd0, round_up};
      end else begin
         hue_wide = {1'b0, offset} + {4'd0, quot};
      end
      hue_in = in_data.gray ? 15'd0 : hue_wide[14:0];
      sat_in = in_data.gray ? 16'd0 : in_data.sat_dq;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         hue_ff    <= hue_in;
         sat_ff    <= sat_in;
         bright_ff <= in_data.hi;
         gray_ff   <= in_data.gray;
      end
   end

   assign out_valid  = valid_ff;
   assign hue        = hue_ff;
   assign saturation = sat_ff;
   assign brightness = bright_ff;
   assign gray       = gray_ff;

endmodule

`default_nettype wire

// ===== hdl/rgb_to_hsv_converter.sv =====
// Channel   Direction  Ports                        Contents
// req_      in         tvalid tready tdata[23:0]    one RGB pixel
// rsp_      out        tvalid tready tdata[39:0]    hue, saturation, brightness
//                      tuser[0:0]                   gray flag
//
// One pixel can be taken in every clock cycle while the result side does not stall.
// A result passes through two front stages (the first loads at the accepting edge),
// sixteen restoring steps that each resolve one bit of both divisions at once,
// and the output register.
// Reset is synchronous and active high; it empties every stage but leaves payload.
// A stalled stage holds its transaction; empty stages are squeezed out before req_tready falls.
`default_nettype none

module rgb_to_hsv_converter
   import r2h_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // red [7:0], green [15:8], blue [23:16]
   input  wire logic [23:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // hue [14:0], saturation [30:15], brightness [38:31], zero [39]
   output logic [39:0]      rsp_tdata,
   // gray [0]
   output logic [0:0]       rsp_tuser
);

   // Handshake and payload between consecutive stages. Entry 0 is the output
   // of the front end, entry DIV_STEPS the output of the last divider step.
   logic    step_valid [DIV_STEPS+1];
   logic    step_ready [DIV_STEPS+1];
   div_type step_data  [DIV_STEPS+1];

   logic [14:0] hue;
   logic [15:0] saturation;
   logic [7:0]  brightness;
   logic        gray;

   // Front end: channel extremes and sector, then the spread and both
   // dividends (65535 times the spread and 3840 times the magnitude of the channel difference).
   r2h_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .red       (req_tdata[7:0]),
      .green     (req_tdata[15:8]),
      .blue      (req_tdata[23:16]),
      .out_valid (step_valid[0]),
      .out_ready (step_ready[0]),
      .out_data  (step_data[0])
   );

   // Divider pipeline: each stage resolves one quotient bit of the saturation
   // division by the brightness and of the hue division by the spread.
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
      r2h_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (step_valid[i]),
         .in_ready  (step_ready[i]),
         .in_data   (step_data[i]),
         .out_valid (step_valid[i+1]),
         .out_ready (step_ready[i+1]),
         .out_data  (step_data[i+1])
      );
   end

   // Output register: hue offset by sector, rounding for negative differences
   // and the gray override.
   r2h_finish u_finish (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (step_valid[DIV_STEPS]),
      .in_ready   (step_ready[DIV_STEPS]),
      .in_data    (step_data[DIV_STEPS]),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .hue        (hue),
      .saturation (saturation),
      .brightness (brightness),
      .gray       (gray)
   );

   assign rsp_tdata = {1'b0, brightness, saturation, hue};
   assign rsp_tuser = gray;

endmodule

`default_nettype wire

// ===== hdl/r2h_checker.sv =====
`default_nettype none

module r2h_checker
   import r2h_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic [0:0]  rsp_tuser
);

   // A stalled result transaction keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // No result is offered in the cycle after a reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid straight after reset");

   // Gray pixels carry zero hue and saturation.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[30:0] == 31'd0)
      else $error("gray pixel with hue or saturation");

   // A coloured pixel has a nonzero brightness and saturation.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[30:15] != 16'd0 && rsp_tdata[38:31] != 8'd0)
      else $error("coloured pixel with zero saturation or brightness");

   // Hue stays below the full circle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[14:0] < HUE_FULL)
      else $error("hue out of range");

endmodule

bind rgb_to_hsv_converter r2h_checker u_checker (.*);

`default_nettype wire
